/* rtl/ssct_pkg.sv */
// shared constants and helpers for the sphere pair collision pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package ssct_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int NORM_FRAC      = 14;
  localparam int NORM_BITS      = 16;
  localparam int QUO_BITS       = NORM_FRAC + 1;
  localparam int NORM_ONE       = 1 << NORM_FRAC;

  // round a bit count up to whole bytes
  function automatic int byte_pad(input int w);
    return ((w + 7) >> 3) << 3;
  endfunction

endpackage

`default_nettype wire

/* rtl/sphere_sphere_collision_test.sv */
// Sphere pair intersection test, one pair of spheres per item, one result per
// item. Fully pipelined: a new item is taken every cycle while in_tready is
// high. Its stages are four front stages for difference, magnitude, squares
// and the exact squared-distance compare, one stage per root bit in the
// square-root pipeline (COORD_BITS+2), two stages for rounding and
// penetration, fifteen divider stages per normal axis, and the output
// register. A two-entry output buffer keeps in_tready a register; in_tready
// only drops while the consumer holds back two results.
// The normal is the zero vector when the centres coincide.
// Depends on ssct_pkg, ssct_sqrt and ssct_div.
`default_nettype none

module sphere_sphere_collision_test #(
  parameter int COORD_BITS = ssct_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ssct_pkg::byte_pad(8 * COORD_BITS - 2),
  localparam int OUT_W = ssct_pkg::byte_pad(COORD_BITS + 4 + 3 * ssct_pkg::NORM_BITS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // center_a_x, center_a_y, center_a_z, radius_a,
  // center_b_x, center_b_y, center_b_z, radius_b
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // hit, penetration, normal_x, normal_y, normal_z
  output logic [OUT_W-1:0]      out_tdata
);
  import ssct_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int RB   = CB + 2;
  localparam int SQW  = 2 * CB + 3;
  localparam int DW   = CB + 2;
  localparam int PW   = CB + 3;
  localparam int NW   = CB + 1 + NORM_FRAC + 1;
  localparam int QB   = QUO_BITS;
  localparam int SSW  = 1 + CB + 3 + 3 * (CB + 1);
  localparam int RES_W = 1 + PW + 3 * NORM_BITS;

  logic en;
  logic acc;

  logic signed [CB-1:0] ca [3];
  logic signed [CB-1:0] cb [3];
  logic [CB-2:0]        ra;
  logic [CB-2:0]        rb;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign ca[k] = in_tdata[k*CB +: CB];
    assign cb[k] = in_tdata[4*CB-1+k*CB +: CB];
  end
  assign ra = in_tdata[3*CB +: CB-1];
  assign rb = in_tdata[7*CB-1 +: CB-1];

  // front stages
  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [CB:0] d1_r [3];
  logic [CB-1:0]      sumr1_r, sumr2_r, sumr3_r, sumr4_r;
  logic [CB:0]        ad2_r [3];
  logic [CB:0]        ad3_r [3];
  logic [CB:0]        ad4_r [3];
  logic [2:0]         neg2_r, neg3_r, neg4_r;
  logic [2*CB+1:0]    p3_r [3];
  logic [2*CB-1:0]    rsq3_r;
  logic [SQW-1:0]     sq4_r;
  logic               hit4_r;
  logic [SQW-1:0]     sq_nxt;

  assign acc = in_tvalid & in_tready;
  assign sq_nxt = SQW'(p3_r[0]) + SQW'(p3_r[1]) + SQW'(p3_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]   <= {ca[k][CB-1], ca[k]} - {cb[k][CB-1], cb[k]};
        ad2_r[k]  <= d1_r[k][CB] ? (CB+1)'(-d1_r[k]) : (CB+1)'(d1_r[k]);
        neg2_r[k] <= d1_r[k][CB];
        p3_r[k]   <= (2*CB+2)'(ad2_r[k]) * (2*CB+2)'(ad2_r[k]);
        ad3_r[k]  <= ad2_r[k];
        ad4_r[k]  <= ad3_r[k];
      end
      sumr1_r <= {1'b0, ra} + {1'b0, rb};
      sumr2_r <= sumr1_r;
      sumr3_r <= sumr2_r;
      sumr4_r <= sumr3_r;
      rsq3_r  <= (2*CB)'(sumr2_r) * (2*CB)'(sumr2_r);
      neg3_r  <= neg2_r;
      neg4_r  <= neg3_r;
      sq4_r   <= sq_nxt;
      hit4_r  <= (sq_nxt <= SQW'(rsq3_r));
    end
  end

  // square root of the squared distance
  logic            sv_o;
  logic [RB-1:0]   root_o;
  logic [RB+1:0]   rem_o;
  logic [SSW-1:0]  sside_o;

  ssct_sqrt #(.RB(RB), .SIDE_W(SSW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v4_r),
    .in_x     ((2*RB)'(sq4_r)),
    .in_side  ({hit4_r, sumr4_r, neg4_r, ad4_r[2], ad4_r[1], ad4_r[0]}),
    .out_v    (sv_o),
    .out_root (root_o),
    .out_rem  (rem_o),
    .out_side (sside_o)
  );

  // round the distance to nearest, ties up: remainder above root means past the half step
  logic            v5_r, v6_r;
  logic [DW-1:0]   dist5_r, dist6_r;
  logic [SSW-1:0]  side5_r;
  logic [CB:0]     ad5 [3];
  logic [CB-1:0]   sumr5;
  logic [2:0]      neg5;
  logic            hit5;
  logic [PW-1:0]   pen6_r;
  logic [NW-1:0]   num6_r [3];
  logic [2:0]      neg6_r;
  logic            hit6_r;
  logic            dz6_r;

  assign ad5[0] = side5_r[CB:0];
  assign ad5[1] = side5_r[2*CB+1:CB+1];
  assign ad5[2] = side5_r[3*CB+2:2*CB+2];
  assign neg5   = side5_r[3*CB+5:3*CB+3];
  assign sumr5  = side5_r[4*CB+5:3*CB+6];
  assign hit5   = side5_r[SSW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= sv_o;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist5_r <= DW'(root_o + RB'(rem_o > {2'b00, root_o}));
      side5_r <= sside_o;
      dist6_r <= dist5_r;
      pen6_r  <= PW'(sumr5) - PW'(dist5_r);
      for (int k = 0; k < 3; k++) begin
        num6_r[k] <= {ad5[k], {NORM_FRAC{1'b0}}} + NW'(dist5_r >> 1);
      end
      neg6_r  <= neg5;
      hit6_r  <= hit5;
      dz6_r   <= (dist5_r == '0);
    end
  end

  // one divider per normal axis
  localparam int XSW = PW + 3;
  logic          dv_o [3];
  logic [QB-1:0] q_o  [3];
  logic [XSW-1:0] xside_o;
  logic [1:0]    yside_o, zside_o;

  ssct_div #(.NW(NW), .DW(DW), .SIDE_W(XSW)) u_div_x (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_v (v6_r), .in_num (num6_r[0]), .in_den (dist6_r),
    .in_side ({hit6_r, pen6_r, dz6_r, neg6_r[0]}),
    .out_v (dv_o[0]), .out_q (q_o[0]), .out_side (xside_o)
  );

  ssct_div #(.NW(NW), .DW(DW), .SIDE_W(2)) u_div_y (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_v (v6_r), .in_num (num6_r[1]), .in_den (dist6_r),
    .in_side ({dz6_r, neg6_r[1]}),
    .out_v (dv_o[1]), .out_q (q_o[1]), .out_side (yside_o)
  );

  ssct_div #(.NW(NW), .DW(DW), .SIDE_W(2)) u_div_z (
    .clk (clk), .rst_n (rst_n), .en (en),
    .in_v (v6_r), .in_num (num6_r[2]), .in_den (dist6_r),
    .in_side ({dz6_r, neg6_r[2]}),
    .out_v (dv_o[2]), .out_q (q_o[2]), .out_side (zside_o)
  );

  logic                 pipe_v;
  logic [2:0]           dz_o;
  logic [2:0]           ng_o;
  logic [NORM_BITS-1:0] nrm [3];
  logic [RES_W-1:0]     res;

  assign dz_o = {zside_o[1], yside_o[1], xside_o[1]};
  assign ng_o = {zside_o[0], yside_o[0], xside_o[0]};

  always_comb begin
    logic [QB-1:0] qc;
    for (int k = 0; k < 3; k++) begin
      qc = q_o[k];
      if (dz_o[k]) begin
        qc = '0;
      end else if (qc > QB'(NORM_ONE)) begin
        qc = QB'(NORM_ONE);
      end
      nrm[k] = ng_o[k] ? NORM_BITS'(-{1'b0, qc}) : NORM_BITS'({1'b0, qc});
    end
  end

  assign pipe_v = dv_o[0] & dv_o[1] & dv_o[2];
  assign res    = {nrm[2], nrm[1], nrm[0], xside_o[XSW-2:2], xside_o[XSW-1]};

  // output register plus skid entry
  logic             ov_r, ov_nxt;
  logic             sk_r, sk_nxt;
  logic [RES_W-1:0] od_r, od_nxt;
  logic [RES_W-1:0] skd_r, skd_nxt;

  assign en        = ~sk_r;
  assign in_tready = en;

  always_comb begin
    ov_nxt  = ov_r;
    sk_nxt  = sk_r;
    od_nxt  = od_r;
    skd_nxt = skd_r;
    if (sk_r) begin
      if (out_tready) begin
        od_nxt = skd_r;
        sk_nxt = 1'b0;
      end
    end else if (pipe_v) begin
      if (!ov_r || out_tready) begin
        od_nxt = res;
        ov_nxt = 1'b1;
      end else begin
        skd_nxt = res;
        sk_nxt  = 1'b1;
      end
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sk_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sk_r <= sk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r  <= od_nxt;
    skd_r <= skd_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'(od_r);

endmodule

`default_nettype wire

/* rtl/ssct_sqrt.sv */
// pipelined integer square root, one result bit per register stage
// returns floor root and remainder; uses ssct_pkg
`default_nettype none

module ssct_sqrt #(
  parameter int RB     = 34,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [2*RB-1:0]   in_x,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_v,
  output logic [RB-1:0]          out_root,
  output logic [RB+1:0]          out_rem,
  output logic [SIDE_W-1:0]      out_side
);
  import ssct_pkg::*;

  localparam int XW = 2 * RB;

  logic              v_r    [RB];
  logic [RB+1:0]     rem_r  [RB];
  logic [RB-1:0]     root_r [RB];
  logic [XW-1:0]     x_r    [RB];
  logic [SIDE_W-1:0] side_r [RB];

  for (genvar i = 0; i < RB; i++) begin : g_st
    logic              v_i;
    logic [RB+1:0]     rem_i;
    logic [RB-1:0]     root_i;
    logic [XW-1:0]     x_i;
    logic [SIDE_W-1:0] side_i;
    logic [RB+1:0]     t;
    logic [RB+1:0]     trial;
    logic              ge;
    logic [RB+1:0]     rem_nxt;
    logic [RB-1:0]     root_nxt;

    if (i == 0) begin : g_first
      assign v_i    = in_v;
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = in_x;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign x_i    = x_r[i-1];
      assign side_i = side_r[i-1];
    end

    // remainder never exceeds twice the partial root, so its low RB bits suffice
    assign t        = {rem_i[RB-1:0], x_i[XW-1 -: 2]};
    assign trial    = {root_i, 2'b01};
    assign ge       = (t >= trial);
    assign rem_nxt  = ge ? (t - trial) : t;
    assign root_nxt = {root_i[RB-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        x_r[i]    <= x_i << 2;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_v    = v_r[RB-1];
  assign out_root = root_r[RB-1];
  assign out_rem  = rem_r[RB-1];
  assign out_side = side_r[RB-1];

endmodule

`default_nettype wire

/* rtl/ssct_div.sv */
// pipelined restoring divider, one quotient bit per register stage
// numerator must be below divisor times two to the quotient width; uses ssct_pkg
`default_nettype none

module ssct_div #(
  parameter int NW     = 48,
  parameter int DW     = 34,
  parameter int SIDE_W = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_v,
  input  wire logic [NW-1:0]                 in_num,
  input  wire logic [DW-1:0]                 in_den,
  input  wire logic [SIDE_W-1:0]             in_side,
  output logic                               out_v,
  output logic [ssct_pkg::QUO_BITS-1:0]      out_q,
  output logic [SIDE_W-1:0]                  out_side
);
  import ssct_pkg::*;

  localparam int QB = QUO_BITS;

  logic              v_r    [QB];
  logic [DW:0]       rem_r  [QB];
  logic [QB-1:0]     q_r    [QB];
  logic [QB-1:0]     n_r    [QB];
  logic [DW-1:0]     d_r    [QB];
  logic [SIDE_W-1:0] side_r [QB];

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic              v_i;
    logic [DW:0]       rem_i;
    logic [QB-1:0]     q_i;
    logic [QB-1:0]     n_i;
    logic [DW-1:0]     d_i;
    logic [SIDE_W-1:0] side_i;
    logic [DW+1:0]     t;
    logic [DW+1:0]     diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_i    = in_v;
      assign rem_i  = (DW+1)'(in_num >> QB);
      assign q_i    = '0;
      assign n_i    = in_num[QB-1:0];
      assign d_i    = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign q_i    = q_r[i-1];
      assign n_i    = n_r[i-1];
      assign d_i    = d_r[i-1];
      assign side_i = side_r[i-1];
    end

    assign t    = {rem_i, n_i[QB-1]};
    assign diff = t - {2'b00, d_i};
    assign ge   = (t >= {2'b00, d_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DW:0] : t[DW:0];
        q_r[i]    <= {q_i[QB-2:0], ge};
        n_r[i]    <= n_i << 1;
        d_r[i]    <= d_i;
        side_r[i] <= side_i;
      end
    end
  end

  assign out_v    = v_r[QB-1];
  assign out_q    = q_r[QB-1];
  assign out_side = side_r[QB-1];

endmodule

`default_nettype wire

/* rtl/ssct_chk.sv */
// port-level checker for the sphere pair collision block, bound to the top level
// depends on ssct_pkg and sphere_sphere_collision_test
`default_nettype none

module ssct_chk #(
  parameter int COORD_BITS = ssct_pkg::COORD_BITS_DEF,
  localparam int OUT_W = ssct_pkg::byte_pad(COORD_BITS + 4 + 3 * ssct_pkg::NORM_BITS)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  import ssct_pkg::*;

  localparam int PEN_MSB = COORD_BITS + 3;
  localparam int NX      = COORD_BITS + 4;

  logic signed [NORM_BITS-1:0] nx, ny, nz;
  assign nx = out_tdata[NX +: NORM_BITS];
  assign ny = out_tdata[NX+NORM_BITS +: NORM_BITS];
  assign nz = out_tdata[NX+2*NORM_BITS +: NORM_BITS];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  a_hit_pen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[PEN_MSB])
    else $error("hit with negative penetration");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> nx <= NORM_ONE && nx >= -NORM_ONE && ny <= NORM_ONE
      && ny >= -NORM_ONE && nz <= NORM_ONE && nz >= -NORM_ONE)
    else $error("normal component out of range");

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready)
    else $error("input held off after a result was taken");

endmodule

bind sphere_sphere_collision_test ssct_chk #(.COORD_BITS(COORD_BITS)) u_ssct_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
